// ===== rtl/kplk_pkg.sv =====
// Package with the codes, payload types and helper functions of the keypad lock controller.
`timescale 1ns / 1ps
`default_nettype none
package kplk_pkg;

  localparam int PIN_DIGITS_DEF = 8;

  localparam int KIND_W   = 3;
  localparam int ACTOR_W  = 3;
  localparam int STATE_W  = 3;
  localparam int DIGITS_W = 32;
  localparam int LEN_W    = 4;
  localparam int OUTC_W   = 3;
  localparam int ELAPSED_W = 24;
  localparam int FAIL_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // Event kinds.
  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACTIVITY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UNLOCK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CHANGE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOCK     = 3'd4;

  // Lock states.
  localparam logic [STATE_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [STATE_W-1:0] ST_UNLOCKED = 3'd1;
  localparam logic [STATE_W-1:0] ST_ENTERING = 3'd2;
  localparam logic [STATE_W-1:0] ST_CHANGING = 3'd3;
  localparam logic [STATE_W-1:0] ST_BLOCKED  = 3'd4;

  // Outcome codes.
  localparam logic [OUTC_W-1:0] OC_SUCCESS = 3'd0;
  localparam logic [OUTC_W-1:0] OC_DENIED  = 3'd1;
  localparam logic [OUTC_W-1:0] OC_ALREADY = 3'd2;
  localparam logic [OUTC_W-1:0] OC_WRONG   = 3'd3;
  localparam logic [OUTC_W-1:0] OC_ERROR   = 3'd4;
  localparam logic [OUTC_W-1:0] OC_NONE    = 3'd5;

  localparam logic [ACTOR_W-1:0] ACTOR_SYSTEM = 3'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_UNLOCK_TIME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES = 3'd3;

  localparam logic [15:0]          UNLOCK_TIME_RST  = 16'd5000;
  localparam logic [23:0]          BLOCK_TIME_RST   = 24'd30000;
  localparam logic [15:0]          IDLE_TIMEOUT_RST = 16'd10000;
  localparam logic [FAIL_W-1:0]    MAX_FAIL_RST     = 4'd3;
  localparam logic [DIGITS_W-1:0]  PIN_RST          = 32'h0000_1234;
  localparam logic [LEN_W-1:0]     PIN_LEN_RST      = 4'd4;
  localparam logic [LEN_W-1:0]     PIN_LEN_MIN      = 4'd4;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX      = '1;
  localparam logic [FAIL_W-1:0]    FAIL_MAX         = '1;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ACTOR_W-1:0]  actor;
    logic [STATE_W-1:0]  target_state;
    logic [DIGITS_W-1:0] pin_digits;
    logic [LEN_W-1:0]    pin_len;
    logic [DIGITS_W-1:0] old_digits;
    logic [LEN_W-1:0]    old_len;
  } in_item_t;

  typedef struct packed {
    logic [OUTC_W-1:0]    outcome;
    logic [STATE_W-1:0]   state_now;
    logic [ACTOR_W-1:0]   source_now;
    logic [ELAPSED_W-1:0] block_left_ms;
    logic                 open_pulse;
    logic                 close_pulse;
  } out_item_t;

  typedef struct packed {
    logic [15:0]       unlock_time_ms;
    logic [23:0]       block_time_ms;
    logic [15:0]       idle_timeout_ms;
    logic [FAIL_W-1:0] max_failures;
  } kplk_cfg_t;

  // Control state of the lock, without the stored PIN.
  typedef struct packed {
    logic [STATE_W-1:0]   lock_state;
    logic [ACTOR_W-1:0]   last_actor;
    logic [FAIL_W-1:0]    failed_count;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } kplk_ctrl_t;

  // Mask that keeps the low len nibbles of a PIN word.
  function automatic logic [DIGITS_W-1:0] nibble_mask(input logic [LEN_W-1:0] len);
    logic [DIGITS_W-1:0] m;
    m = '0;
    for (int i = 0; i < DIGITS_W / 4; i++) begin
      if (LEN_W'(i) < len) begin
        m[4*i +: 4] = 4'hF;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/keypad_lock_controller_unit.sv =====
// Top level of the keypad lock controller with lockout.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------
//   in_     | input     | in_valid/in_stall  | in_data  (in_item_t)
//   out_    | output    | out_valid/out_stall| out_data (out_item_t)
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// One event is taken per clock cycle while in_stall is low. An accepted event
// is held in the input register, the step logic then updates the lock state
// and loads the result register, so each result passes through the input
// register and then the result register before it is on out_data.
// The combinational state update between the two registers sets the rate.
// Reset (rst_n low at a clock edge) empties both registers, restores the
// stored PIN, the counters and the configuration to their defaults.
// When out_stall holds the result register, the input register keeps one more
// event and in_stall rises only once both are occupied.
`timescale 1ns / 1ps
`default_nettype none
module keypad_lock_controller_unit #(
  parameter int PIN_DIGITS = kplk_pkg::PIN_DIGITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire kplk_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output kplk_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [kplk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kplk_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import kplk_pkg::*;

  localparam int USABLE_DIGITS = (PIN_DIGITS < 8) ? PIN_DIGITS : 8;
  localparam int PIN_W = 4 * USABLE_DIGITS;

  // Pipeline registers.
  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;

  // Lock state and configuration.
  kplk_cfg_t        cfg_r;
  kplk_ctrl_t       ctrl_r;
  kplk_ctrl_t       ctrl_nxt;
  logic [PIN_W-1:0] pin_r;
  logic [PIN_W-1:0] pin_nxt;
  logic [LEN_W-1:0] pin_len_r;
  logic [LEN_W-1:0] pin_len_nxt;
  out_item_t        result;

  logic pipe_move;
  logic in_xfer;

  // The result register can take a new value when it is empty or its
  // content is being transferred out in this cycle.
  assign pipe_move = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !pipe_move;
  assign in_xfer   = in_valid && !in_stall;

  kplk_step #(.PIN_DIGITS(PIN_DIGITS)) u_step (
    .cfg        (cfg_r),
    .item       (in_item_r),
    .cur        (ctrl_r),
    .cur_pin    (pin_r),
    .cur_pin_len(pin_len_r),
    .nxt        (ctrl_nxt),
    .nxt_pin    (pin_nxt),
    .nxt_pin_len(pin_len_nxt),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      ctrl_r.lock_state   <= ST_IDLE;
      ctrl_r.last_actor   <= ACTOR_SYSTEM;
      ctrl_r.failed_count <= '0;
      ctrl_r.elapsed_ms   <= '0;
      pin_r               <= PIN_RST[PIN_W-1:0];
      pin_len_r           <= PIN_LEN_RST;
      cfg_r.unlock_time_ms  <= UNLOCK_TIME_RST;
      cfg_r.block_time_ms   <= BLOCK_TIME_RST;
      cfg_r.idle_timeout_ms <= IDLE_TIMEOUT_RST;
      cfg_r.max_failures    <= MAX_FAIL_RST;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (pipe_move) begin
        out_valid_r <= in_valid_r;
        // The state moves on only when an event leaves the input register.
        if (in_valid_r) begin
          ctrl_r    <= ctrl_nxt;
          pin_r     <= pin_nxt;
          pin_len_r <= pin_len_nxt;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_UNLOCK_TIME:  cfg_r.unlock_time_ms  <= cfg_wdata[15:0];
          REG_BLOCK_TIME:   cfg_r.block_time_ms   <= cfg_wdata[23:0];
          REG_IDLE_TIMEOUT: cfg_r.idle_timeout_ms <= cfg_wdata[15:0];
          REG_MAX_FAILURES: cfg_r.max_failures    <= cfg_wdata[FAIL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_data;
    end
    if (pipe_move && in_valid_r) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire

// ===== rtl/kplk_pin_match.sv =====
// Comparator of an offered PIN against the stored PIN.
`timescale 1ns / 1ps
`default_nettype none
module kplk_pin_match #(
  parameter int PIN_DIGITS = kplk_pkg::PIN_DIGITS_DEF
) (
  input  wire logic [kplk_pkg::DIGITS_W-1:0]                        digits,
  input  wire logic [kplk_pkg::LEN_W-1:0]                           len,
  input  wire logic [4*((PIN_DIGITS < 8) ? PIN_DIGITS : 8)-1:0]     stored_pin,
  input  wire logic [kplk_pkg::LEN_W-1:0]                           stored_len,
  output logic                                                      match
);
  import kplk_pkg::*;

  localparam int USABLE_DIGITS = (PIN_DIGITS < 8) ? PIN_DIGITS : 8;
  localparam int PIN_W = 4 * USABLE_DIGITS;

  logic [DIGITS_W-1:0] full_mask;
  logic [PIN_W-1:0]    mask;

  assign full_mask = nibble_mask(len);
  assign mask      = full_mask[PIN_W-1:0];

  // Lengths beyond the usable digit count never match.
  assign match = (len <= LEN_W'(USABLE_DIGITS)) && (len == stored_len) &&
                 ((digits[PIN_W-1:0] & mask) == (stored_pin & mask));

endmodule
`default_nettype wire

// ===== rtl/kplk_step.sv =====
// Next-state and result logic for one lock event.
`timescale 1ns / 1ps
`default_nettype none
module kplk_step #(
  parameter int PIN_DIGITS = kplk_pkg::PIN_DIGITS_DEF
) (
  input  wire kplk_pkg::kplk_cfg_t                            cfg,
  input  wire kplk_pkg::in_item_t                             item,
  input  wire kplk_pkg::kplk_ctrl_t                           cur,
  input  wire logic [4*((PIN_DIGITS < 8) ? PIN_DIGITS : 8)-1:0] cur_pin,
  input  wire logic [kplk_pkg::LEN_W-1:0]                     cur_pin_len,
  output kplk_pkg::kplk_ctrl_t                                nxt,
  output logic [4*((PIN_DIGITS < 8) ? PIN_DIGITS : 8)-1:0]    nxt_pin,
  output logic [kplk_pkg::LEN_W-1:0]                          nxt_pin_len,
  output kplk_pkg::out_item_t                                 result
);
  import kplk_pkg::*;

  localparam int USABLE_DIGITS = (PIN_DIGITS < 8) ? PIN_DIGITS : 8;
  localparam int PIN_W = 4 * USABLE_DIGITS;

  logic                 new_match;
  logic                 old_match;
  logic [ELAPSED_W-1:0] el_inc;
  logic [FAIL_W-1:0]    fail_inc;
  logic                 fail_block;
  logic [DIGITS_W-1:0]  new_mask;
  logic [OUTC_W-1:0]    outcome;
  logic                 open_p;
  logic                 close_p;

  kplk_pin_match #(.PIN_DIGITS(PIN_DIGITS)) u_new_match (
    .digits    (item.pin_digits),
    .len       (item.pin_len),
    .stored_pin(cur_pin),
    .stored_len(cur_pin_len),
    .match     (new_match)
  );

  kplk_pin_match #(.PIN_DIGITS(PIN_DIGITS)) u_old_match (
    .digits    (item.old_digits),
    .len       (item.old_len),
    .stored_pin(cur_pin),
    .stored_len(cur_pin_len),
    .match     (old_match)
  );

  assign el_inc     = (cur.elapsed_ms != ELAPSED_MAX) ? cur.elapsed_ms + 1'b1 : cur.elapsed_ms;
  assign fail_inc   = (cur.failed_count != FAIL_MAX) ? cur.failed_count + 1'b1 : cur.failed_count;
  assign fail_block = (fail_inc >= cfg.max_failures);
  assign new_mask   = nibble_mask(item.pin_len);

  always_comb begin
    nxt         = cur;
    nxt_pin     = cur_pin;
    nxt_pin_len = cur_pin_len;
    outcome     = OC_ERROR;
    open_p      = 1'b0;
    close_p     = 1'b0;

    unique case (item.kind)
      KIND_TICK: begin
        nxt.elapsed_ms = el_inc;
        outcome        = OC_NONE;
        if (cur.lock_state == ST_UNLOCKED && el_inc >= ELAPSED_W'(cfg.unlock_time_ms)) begin
          nxt.lock_state = ST_IDLE;
          nxt.last_actor = ACTOR_SYSTEM;
          close_p        = 1'b1;
          outcome        = OC_SUCCESS;
        end else if (cur.lock_state == ST_BLOCKED && el_inc >= cfg.block_time_ms) begin
          nxt.failed_count = '0;
          nxt.lock_state   = ST_IDLE;
          nxt.last_actor   = ACTOR_SYSTEM;
          outcome          = OC_SUCCESS;
        end else if ((cur.lock_state == ST_ENTERING || cur.lock_state == ST_CHANGING) &&
                     el_inc >= ELAPSED_W'(cfg.idle_timeout_ms)) begin
          nxt.lock_state = ST_IDLE;
          nxt.last_actor = ACTOR_SYSTEM;
          outcome        = OC_SUCCESS;
        end
      end
      KIND_ACTIVITY: begin
        if (cur.lock_state == ST_BLOCKED) begin
          outcome = OC_NONE;
        end else if (item.target_state > ST_BLOCKED) begin
          outcome = OC_ERROR;
        end else begin
          nxt.lock_state = item.target_state;
          nxt.last_actor = item.actor;
          nxt.elapsed_ms = '0;
          outcome        = OC_SUCCESS;
        end
      end
      KIND_UNLOCK: begin
        if (cur.lock_state == ST_BLOCKED) begin
          outcome = OC_DENIED;
        end else if (cur.lock_state == ST_UNLOCKED) begin
          outcome = OC_ALREADY;
        end else if (new_match) begin
          nxt.failed_count = '0;
          nxt.lock_state   = ST_UNLOCKED;
          nxt.last_actor   = item.actor;
          nxt.elapsed_ms   = '0;
          open_p           = 1'b1;
          outcome          = OC_SUCCESS;
        end else begin
          nxt.failed_count = fail_inc;
          nxt.last_actor   = item.actor;
          nxt.lock_state   = fail_block ? ST_BLOCKED : ST_IDLE;
          if (fail_block) begin
            nxt.elapsed_ms = '0;
          end
          outcome = OC_WRONG;
        end
      end
      KIND_CHANGE: begin
        if (cur.lock_state == ST_BLOCKED) begin
          outcome = OC_DENIED;
        end else if (!old_match) begin
          nxt.failed_count = fail_inc;
          nxt.last_actor   = item.actor;
          nxt.lock_state   = fail_block ? ST_BLOCKED : ST_IDLE;
          if (fail_block) begin
            nxt.elapsed_ms = '0;
          end
          outcome = OC_WRONG;
        end else if (item.pin_len < PIN_LEN_MIN || item.pin_len > LEN_W'(USABLE_DIGITS)) begin
          nxt.lock_state = ST_IDLE;
          outcome        = OC_ERROR;
        end else begin
          nxt_pin          = item.pin_digits[PIN_W-1:0] & new_mask[PIN_W-1:0];
          nxt_pin_len      = item.pin_len;
          nxt.failed_count = '0;
          nxt.lock_state   = ST_IDLE;
          nxt.last_actor   = item.actor;
          outcome          = OC_SUCCESS;
        end
      end
      KIND_LOCK: begin
        if (cur.lock_state == ST_IDLE) begin
          outcome = OC_ALREADY;
        end else begin
          nxt.lock_state = ST_IDLE;
          nxt.last_actor = item.actor;
          close_p        = 1'b1;
          outcome        = OC_SUCCESS;
        end
      end
      default: begin
        outcome = OC_ERROR;
      end
    endcase
  end

  always_comb begin
    result.outcome     = outcome;
    result.state_now   = nxt.lock_state;
    result.source_now  = nxt.last_actor;
    result.open_pulse  = open_p;
    result.close_pulse = close_p;
    if (nxt.lock_state == ST_BLOCKED && nxt.elapsed_ms < cfg.block_time_ms) begin
      result.block_left_ms = cfg.block_time_ms - nxt.elapsed_ms;
    end else begin
      result.block_left_ms = '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kplk_checker.sv =====
// Port-level checker for the keypad lock controller and its bind.
`timescale 1ns / 1ps
`default_nettype none
module kplk_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire kplk_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire kplk_pkg::out_item_t out_data
);
  import kplk_pkg::*;

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The input waits only behind a stalled result, and a waiting event holds still.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall ##1 in_valid && $stable(in_data))
    else $error("input stalled without a stalled result or changed while waiting");

  // Lockout time is reported only while blocked.
  a_block_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.block_left_ms != '0) |-> out_data.state_now == ST_BLOCKED)
    else $error("block time left outside the blocked state");

  // An open command is a successful unlock.
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.open_pulse |->
      out_data.state_now == ST_UNLOCKED && out_data.outcome == OC_SUCCESS &&
      !out_data.close_pulse)
    else $error("open pulse without a successful unlock");

  // A close command always leaves the lock idle.
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.close_pulse |->
      out_data.state_now == ST_IDLE && out_data.outcome == OC_SUCCESS)
    else $error("close pulse without the lock going idle");

endmodule

bind keypad_lock_controller_unit kplk_checker u_kplk_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
`default_nettype wire
